### hdl/ptwc_pkg.sv
// ----------------------------------------------------------------------------
// ptwc_pkg
// shared types and constants for the four-level page table walk checker
// ----------------------------------------------------------------------------
package ptwc_pkg;

  localparam int ENTRIES_PER_PAGE = 512;
  localparam int SLOT_W           = 9;

  // entry bit positions
  localparam int BIT_P  = 0;
  localparam int BIT_RW = 1;
  localparam int BIT_US = 2;
  localparam int BIT_PS = 7;

  localparam int ROOT_W  = 6;
  localparam int FRAME_W = 40;
  localparam int CFG_W   = 40;

  // slave- and master-side tdata widths
  localparam int IN_DATA_W = 128;
  localparam int OUT_DATA_W = 120;

  // item kinds on s_tuser
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // configuration register indexes
  localparam logic CFG_ROOT_PAGE  = 1'b0;
  localparam logic CFG_BASE_FRAME = 1'b1;

  typedef enum logic [2:0] {
    ST_WRITTEN = 3'd0,
    ST_MAPPED  = 3'd1,
    ST_NOTABLE = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_OUTSIDE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    LVL_PML4 = 2'd0,
    LVL_PDPT = 2'd1,
    LVL_PD   = 2'd2,
    LVL_PT   = 2'd3
  } level_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    item_load;
    logic    store_write;
    logic    tbl_read;
    level_t  rd_level;
    logic    res_load;
    status_t res_status;
    logic    out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic root_outside;
    logic present;
    logic page_size;
    logic ptr_outside;
  } stat_t;

  function automatic level_t next_level(level_t lvl);
    level_t nxt;
    case (lvl)
      LVL_PML4: nxt = LVL_PDPT;
      LVL_PDPT: nxt = LVL_PD;
      LVL_PD:   nxt = LVL_PT;
      default:  nxt = LVL_PT;
    endcase
    return nxt;
  endfunction

endpackage

### hdl/ptwc_dp.sv
// ----------------------------------------------------------------------------
// ptwc_dp
// datapath: table store, config registers, entry decode, result and output
// registers
// ----------------------------------------------------------------------------
module ptwc_dp import ptwc_pkg::*; #(
  parameter int TABLE_PAGES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [2:0]            m_tuser
);

  localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_PAGE;
  localparam int PW    = $clog2(TABLE_PAGES);
  localparam int AW    = PW + SLOT_W;

  logic [14:0]        in_store_index;
  logic [63:0]        in_entry;
  logic [47:0]        in_va;
  logic               in_write_req;

  logic [ROOT_W-1:0]  root_page;
  logic [FRAME_W-1:0] base_frame;
  logic [47:0]        va_q;
  logic               write_req_q;

  logic [63:0]        store [DEPTH];
  logic [63:0]        rd_data;

  logic [47:0]        va_cur;
  logic [SLOT_W-1:0]  slot;
  logic [PW-1:0]      rd_page;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               wr_ok;

  logic [FRAME_W-1:0] ptr_frame;
  logic [FRAME_W-1:0] rel;

  status_t            res_status;
  logic [63:0]        res_leaf;
  logic [51:0]        res_frame;
  logic               res_allowed;
  logic               is_mapped;
  logic               has_leaf;

  assign in_store_index = s_tdata[14:0];
  assign in_entry       = s_tdata[78:15];
  assign in_va          = s_tdata[126:79];
  assign in_write_req   = s_tdata[127];

  always_ff @(posedge clk) begin
    if (rst) begin
      root_page  <= '0;
      base_frame <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROOT_PAGE:  root_page  <= cfg_wdata[ROOT_W-1:0];
        CFG_BASE_FRAME: base_frame <= cfg_wdata[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      va_q        <= in_va;
      write_req_q <= in_write_req;
    end
  end

  // entry decode of the last read
  assign ptr_frame = rd_data[51:12];
  assign rel       = ptr_frame - base_frame;

  always_comb begin
    stat.root_outside = 32'(root_page) >= 32'(TABLE_PAGES);
    stat.present      = rd_data[BIT_P];
    stat.page_size    = rd_data[BIT_PS];
    stat.ptr_outside  = (ptr_frame < base_frame) || (rel >= FRAME_W'(TABLE_PAGES));
  end

  // read address: page from root or from the previous entry, slot from the va
  assign va_cur = cmd.item_load ? in_va : va_q;

  always_comb begin
    case (cmd.rd_level)
      LVL_PML4: slot = va_cur[47:39];
      LVL_PDPT: slot = va_cur[38:30];
      LVL_PD:   slot = va_cur[29:21];
      default:  slot = va_cur[20:12];
    endcase
  end

  assign rd_page = (cmd.rd_level == LVL_PML4) ? PW'(root_page) : rel[PW-1:0];
  assign rd_addr = {rd_page, slot};
  assign wr_addr = AW'(in_store_index);
  assign wr_ok   = 32'(in_store_index) < 32'(DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.store_write && wr_ok) begin
      store[wr_addr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_read) begin
      rd_data <= store[rd_addr];
    end
  end

  // result capture
  assign is_mapped = cmd.res_status == ST_MAPPED;
  assign has_leaf  = is_mapped || (cmd.res_status == ST_ABSENT);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status  <= cmd.res_status;
      res_leaf    <= has_leaf ? rd_data : '0;
      res_frame   <= is_mapped ? {rd_data[51:12], 12'b0} : '0;
      res_allowed <= is_mapped && rd_data[BIT_US] && (!write_req_q || rd_data[BIT_RW]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {3'b0, res_allowed, res_frame, res_leaf};
      m_tuser <= res_status;
    end
  end

endmodule

### hdl/ptwc_ctrl.sv
// ----------------------------------------------------------------------------
// ptwc_ctrl
// controller: sequences store writes, the four-level walk and result hand-off
// ----------------------------------------------------------------------------
module ptwc_ctrl import ptwc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  input  logic  s_tuser,
  output logic  s_tready,
  output logic  m_tvalid,
  input  logic  m_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  level_t lvl, lvl_next;
  logic   out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lvl       <= LVL_PML4;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      lvl       <= lvl_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    lvl_next       = lvl;
    s_tready       = 1'b0;
    cmd.item_load   = 1'b0;
    cmd.store_write = 1'b0;
    cmd.tbl_read    = 1'b0;
    cmd.rd_level    = LVL_PML4;
    cmd.res_load    = 1'b0;
    cmd.res_status  = ST_WRITTEN;
    cmd.out_load    = 1'b0;

    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.item_load = 1'b1;
          if (s_tuser == MODE_WRITE) begin
            cmd.store_write = 1'b1;
            cmd.res_load    = 1'b1;
            cmd.res_status  = ST_WRITTEN;
            state_next      = S_DONE;
          end else if (stat.root_outside) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_OUTSIDE;
            state_next     = S_DONE;
          end else begin
            cmd.tbl_read = 1'b1;
            cmd.rd_level = LVL_PML4;
            lvl_next     = LVL_PML4;
            state_next   = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (lvl == LVL_PT) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = stat.present ? ST_MAPPED : ST_ABSENT;
          state_next     = S_DONE;
        end else if (!stat.present || (stat.page_size && lvl != LVL_PML4)) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOTABLE;
          state_next     = S_DONE;
        end else if (stat.ptr_outside) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OUTSIDE;
          state_next     = S_DONE;
        end else begin
          cmd.tbl_read = 1'b1;
          cmd.rd_level = next_level(lvl);
          lvl_next     = next_level(lvl);
        end
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign m_tvalid = out_valid;

  // a write beat goes straight to result hand-off
  a_write_done: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == MODE_WRITE) |=> state == S_DONE)
    else $error("write beat did not reach result hand-off");

  // a store read and a result capture never share a cycle
  a_read_xor_result: assert property (@(posedge clk) disable iff (rst)
    !(cmd.tbl_read && cmd.res_load))
    else $error("store read issued together with result capture");

  // a finished result waits until the output register is free
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !m_tready) |=> state == S_DONE)
    else $error("result dropped while output stalled");

  // the walk only moves deeper while it stays in the walk
  a_walk_advances: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && state_next == S_WALK) |=> lvl != LVL_PML4)
    else $error("walk level did not advance");

endmodule

### hdl/page_table_walk_check.sv
// ----------------------------------------------------------------------------
// page_table_walk_check
// store of page-table pages with a four-level walker and user-access check
// ----------------------------------------------------------------------------
//
// channel  dir  fields
// -------  ---  ------------------------------------------------------------
// s_*      in   tuser: mode; tdata: store_index, entry_value, virtual_address,
//               write_req
// m_*      out  tuser: status; tdata: leaf_entry, frame_address, user_allowed
// cfg_*    in   index 0 root_page, index 1 store_base_frame
//
// a write beat goes straight to result hand-off after acceptance; a lookup
// does one synchronous store read per table level walked
// one item in work at a time: no new input beat until the last result is handed on
// a stalled master side holds a result in the output register, the next one
// in the result register, and s_tready then stays low
// rst is synchronous; the store has no reset, and the user must read it only
// where written: the block itself does not enforce this
module page_table_walk_check import ptwc_pkg::*; #(
  parameter int TABLE_PAGES = 64
) (
  input  logic                  clk,
  input  logic                  rst,

  // mode (bit 0)
  input  logic                  s_tuser,
  // store_index [14:0], entry_value [78:15], virtual_address [126:79],
  // write_req [127]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,

  // status [2:0]
  output logic [2:0]            m_tuser,
  // leaf_entry [63:0], frame_address [115:64], user_allowed [116], zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,

  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing: idle, walk one level per cycle, hand result to output
  ptwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table store, entry decode and result registers
  ptwc_dp #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

### verif/walk_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// walk_result_checker
// watches both stream channels and the register port of the page table
// walker, predicts every result beat and compares it field by field
// ----------------------------------------------------------------------------
module walk_result_checker import ptwc_pkg::*; #(
  parameter int TABLE_PAGES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tuser,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [2:0]            m_tuser,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output int                    errors,
  output int                    pending
);

  localparam int STORE_DEPTH = TABLE_PAGES * ENTRIES_PER_PAGE;

  typedef struct packed {
    status_t     status;
    logic [63:0] leaf;
    logic [51:0] frame;
    logic        user;
  } walk_outcome_t;

  logic [63:0]         page_store [STORE_DEPTH];
  logic [ROOT_W-1:0]   root_page;
  logic [FRAME_W-1:0]  base_frame;
  walk_outcome_t       walk_outcomes [$];
  int                  fail_count = 0;

  assign errors = fail_count;

  // table pointer of an entry to a store page, 0 when it falls outside
  function automatic bit table_page(input logic [63:0] entry, output int unsigned page);
    logic [FRAME_W-1:0] frame;
    logic [FRAME_W-1:0] rel;
    frame = entry[51:12];
    if (frame < base_frame) return 0;
    rel = frame - base_frame;
    if (rel >= FRAME_W'(TABLE_PAGES)) return 0;
    page = 32'(rel);
    return 1;
  endfunction

  function automatic walk_outcome_t translate(input logic [47:0] va, input logic write_req);
    walk_outcome_t res;
    int unsigned   page;
    logic [63:0]   e;
    int            lvl;
    res = '0;
    page = 32'(root_page);
    if (page >= TABLE_PAGES) begin
      res.status = ST_OUTSIDE;
      return res;
    end
    for (lvl = 0; lvl < 3; lvl++) begin
      e = page_store[page * ENTRIES_PER_PAGE + va[47 - 9 * lvl -: SLOT_W]];
      // size bit stops the walk below the top level only
      if (!e[BIT_P] || (lvl > 0 && e[BIT_PS])) begin
        res.status = ST_NOTABLE;
        return res;
      end
      if (!table_page(e, page)) begin
        res.status = ST_OUTSIDE;
        return res;
      end
    end
    e = page_store[page * ENTRIES_PER_PAGE + va[20:12]];
    res.leaf = e;
    if (!e[BIT_P]) begin
      res.status = ST_ABSENT;
      return res;
    end
    res.status = ST_MAPPED;
    res.frame  = {e[51:12], 12'h000};
    res.user   = e[BIT_US] && (!write_req || e[BIT_RW]);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    walk_outcome_t want;
    if (rst) begin
      root_page  = '0;
      base_frame = '0;
      for (int i = 0; i < STORE_DEPTH; i++) page_store[i] = '0;
      walk_outcomes.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (walk_outcomes.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, status %h", $time, m_tuser);
        end else begin
          want = walk_outcomes.pop_front();
          check_field("status", 64'(want.status), 64'(m_tuser));
          check_field("leaf_entry", want.leaf, m_tdata[63:0]);
          check_field("frame_address", 64'(want.frame), 64'(m_tdata[115:64]));
          check_field("user_allowed", 64'(want.user), 64'(m_tdata[116]));
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == MODE_WRITE) begin
          if (s_tdata[14:0] < STORE_DEPTH) page_store[s_tdata[14:0]] = s_tdata[78:15];
          want = '0;
          want.status = ST_WRITTEN;
        end else begin
          want = translate(s_tdata[126:79], s_tdata[127]);
        end
        walk_outcomes.push_back(want);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_ROOT_PAGE) root_page = cfg_wdata[ROOT_W-1:0];
        else base_frame = cfg_wdata[FRAME_W-1:0];
      end
    end
    pending <= walk_outcomes.size();
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the four-level page table walker; builds table
// paths with random content, looks them up under several register settings
// and leaves result checking to walk_result_checker
// ----------------------------------------------------------------------------
module testbench import ptwc_pkg::*;;

  localparam int TABLE_PAGES = 64;
  localparam int STORE_DEPTH = TABLE_PAGES * ENTRIES_PER_PAGE;
  localparam longint unsigned MAX_FRAME = 64'hFF_FFFF_FFFF;

  // entry flag masks
  localparam logic [63:0] P_BIT  = 64'd1 << BIT_P;
  localparam logic [63:0] RW_BIT = 64'd1 << BIT_RW;
  localparam logic [63:0] US_BIT = 64'd1 << BIT_US;
  localparam logic [63:0] PS_BIT = 64'd1 << BIT_PS;

  localparam int PHASE_ITEMS = 86;
  // receiver hold-off: starts once this many results came, mid random part
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 400;
  // the hold-off is the longest quiet span
  localparam int QUIET_LIMIT = 4000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tuser = MODE_WRITE;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [2:0]            m_tuser;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_ROOT_PAGE;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  int errors;
  int pending;

  // stimulus side picture of the store, only to keep walks on written entries
  logic [63:0]       shadow_store [STORE_DEPTH];
  bit                written [STORE_DEPTH];
  logic [ROOT_W-1:0] cur_root = '0;
  longint unsigned   cur_base = 0;
  logic [47:0]       recent_va [$];

  int   items_sent = 0;
  int   results_seen = 0;
  int   quiet = 0;
  logic steady = 1'b0;
  bit   hold_done = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  page_table_walk_check #(.TABLE_PAGES(TABLE_PAGES)) uut (
    .clk(clk), .rst(rst),
    .s_tuser(s_tuser), .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tuser(m_tuser), .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  walk_result_checker #(.TABLE_PAGES(TABLE_PAGES)) walk_check (
    .clk(clk), .rst(rst),
    .s_tuser(s_tuser), .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tuser(m_tuser), .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  // result beat count and watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (m_tvalid && m_tready) results_seen <= results_seen + 1;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL page_table_walk_check");
      $finish;
    end
  end

  // receiver: random stalls, none while steady, one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (!hold_done && results_seen == HOLD_AT) begin
        hold_done = 1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= steady || ($urandom_range(99) >= 36);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pointer_to(input longint unsigned frame);
    return (frame << 12) | P_BIT;
  endfunction

  // frame just off or well off the store window, on either side
  function automatic longint unsigned outside_frame();
    longint unsigned past_end;
    past_end = cur_base + TABLE_PAGES;
    if (past_end <= MAX_FRAME && (cur_base == 0 || $urandom_range(1))) begin
      if ($urandom_range(3) == 0) return past_end;
      return past_end + (rand64() % (MAX_FRAME - past_end + 1));
    end
    if ($urandom_range(3) == 0) return cur_base - 1;
    return rand64() % cur_base;
  endfunction

  // random entry for a table level; upper levels mostly point into the store
  function automatic logic [63:0] make_entry(input int lvl);
    logic [63:0]     e;
    longint unsigned frame;
    int              r;
    e = rand64();
    r = $urandom_range(99);
    if (lvl == 3) begin
      e[BIT_P] = (r >= 15);
      return e;
    end
    frame = cur_base + $urandom_range(TABLE_PAGES - 1);
    if (frame > MAX_FRAME) frame = cur_base;
    if (r >= 14 && r < 20) frame = outside_frame();
    e[51:12]  = frame[FRAME_W-1:0];
    e[BIT_P]  = (r >= 8);
    e[BIT_PS] = (r >= 8 && r < 14);
    return e;
  endfunction

  // first unwritten store entry that a lookup of va would read
  function automatic bit unwritten_on_path(input logic [47:0] va, output int pos,
                                           output int lvl);
    longint unsigned page;
    longint unsigned frame;
    logic [63:0]     e;
    page = 64'(cur_root);
    for (int l = 0; l < 4; l++) begin
      pos = int'(page * ENTRIES_PER_PAGE + va[47 - 9 * l -: SLOT_W]);
      lvl = l;
      if (!written[pos]) return 1;
      e = shadow_store[pos];
      if (l == 3 || !e[BIT_P] || (l > 0 && e[BIT_PS])) return 0;
      frame = 64'(e[51:12]);
      if (frame < cur_base || frame - cur_base >= TABLE_PAGES) return 0;
      page = frame - cur_base;
    end
    return 0;
  endfunction

  task automatic send_item(input logic mode, input logic [IN_DATA_W-1:0] data);
    while (!steady && $urandom_range(99) < 36) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // unused fields of a beat carry random bits
  task automatic put_entry(input int idx, input logic [63:0] value);
    shadow_store[idx] = value;
    written[idx] = 1;
    send_item(MODE_WRITE, {1'($urandom), 48'(rand64()), value, 15'(idx)});
  endtask

  // fills in any unwritten entry the walk would touch, then looks up
  task automatic look_up(input logic [47:0] va, input logic write_req);
    int pos;
    int lvl;
    while (unwritten_on_path(va, pos, lvl)) put_entry(pos, make_entry(lvl));
    send_item(MODE_LOOKUP, {write_req, va, rand64(), 15'($urandom)});
  endtask

  // registers change only once every result is back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [ROOT_W-1:0] root, input longint unsigned base);
    wait_idle();
    cur_root = root;
    cur_base = base;
    recent_va.delete();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROOT_PAGE;
    cfg_wdata <= CFG_W'(root);
    @(posedge clk);
    cfg_index <= CFG_BASE_FRAME;
    cfg_wdata <= base[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          r;
    int          phase_start;
    logic [47:0] va;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_config('0, 0);

    // directed: one path through pages 0..3 at slot 0 of every level
    put_entry(0, pointer_to(1) | PS_BIT);           // size bit ignored at the top
    put_entry(ENTRIES_PER_PAGE, pointer_to(2));
    put_entry(2 * ENTRIES_PER_PAGE, pointer_to(3));
    put_entry(3 * ENTRIES_PER_PAGE, '1);            // leaf with every bit set
    look_up(48'h0, 1'b1);
    look_up(48'h0000_0000_0fff, 1'b0);              // offset bits ignored
    // read-only user page: write denied, read granted
    put_entry(3 * ENTRIES_PER_PAGE, (64'h12345 << 12) | P_BIT | US_BIT);
    look_up(48'h0, 1'b1);
    look_up(48'h0, 1'b0);
    // leaf not present, raw entry still returned
    put_entry(3 * ENTRIES_PER_PAGE + 1, (64'h54321 << 12) | RW_BIT | US_BIT);
    look_up(48'h1000, 1'b0);
    // supervisor page with high bits set
    put_entry(3 * ENTRIES_PER_PAGE + 2, 64'hfff0_0000_0000_0000 | P_BIT | RW_BIT);
    look_up(48'h2abc, 1'b1);
    // large page at the pdpt and at the pd level
    put_entry(ENTRIES_PER_PAGE + 1, pointer_to(2) | PS_BIT);
    look_up(48'h0000_4000_0000, 1'b0);
    put_entry(2 * ENTRIES_PER_PAGE + 1, pointer_to(3) | PS_BIT);
    look_up(48'h0000_0020_0000, 1'b0);
    // absent top-level entry, reached by the all-ones address
    put_entry(ENTRIES_PER_PAGE - 1, 64'h0);
    look_up('1, 1'b1);
    // pointer one page past the store
    put_entry(2, pointer_to(TABLE_PAGES));
    look_up(48'h0100_0000_0000, 1'b0);
    put_entry(STORE_DEPTH - 1, rand64());

    // random phases under different register settings
    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: set_config('1, MAX_FRAME);
        2: set_config(ROOT_W'($urandom), MAX_FRAME - TABLE_PAGES + 1);
        3: set_config(ROOT_W'($urandom), rand64() & MAX_FRAME);
        4: set_config(ROOT_W'($urandom), $urandom_range(200));
        default: set_config('0, 0);
      endcase
      // one phase runs with no idling on either side
      steady <= (ph == 4);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 12) begin
          // noise: random entry anywhere, may break an existing path
          put_entry($urandom_range(STORE_DEPTH - 1), rand64());
        end else begin
          if (recent_va.size() > 0 && r < 65) begin
            va = recent_va[$urandom_range(recent_va.size() - 1)];
            va[11:0] = 12'($urandom);
            if ($urandom_range(4) == 0) va[20:12] = 9'($urandom);
          end else begin
            va = 48'(rand64());
          end
          look_up(va, 1'($urandom));
          recent_va.push_back(va);
          if (recent_va.size() > 16) void'(recent_va.pop_front());
        end
      end
    end
    steady <= 1'b0;

    wait_idle();
    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
    if (errors == 0 && pending == 0) begin
      $display("PASS page_table_walk_check");
    end else begin
      $display("FAIL page_table_walk_check");
    end
    $finish;
  end

endmodule
